### rtl/cylinder_group_geometry_planner_defines.svh
// Assertion macros for the cylinder group geometry planner checker
`ifndef CYLINDER_GROUP_GEOMETRY_PLANNER_DEFINES_SVH
`define CYLINDER_GROUP_GEOMETRY_PLANNER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CGP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cgp_pkg.sv
// Shared types and constants of the cylinder group geometry planner
`timescale 1ns / 1ps
package cgp_pkg;

  localparam int BLOCK_BITS = 32;
  localparam int BLK_W      = 31;
  localparam int REQG_W     = 16;
  localparam int SIZE_W     = 24;
  localparam int MING_W     = 12;
  localparam int MINB_W     = 16;
  localparam int GRP_W      = 17;
  localparam int PROD_W     = GRP_W + SIZE_W;
  localparam int WASTE_W    = 26;
  localparam int DIV_NW     = BLK_W;
  localparam int DIV_DW     = SIZE_W;
  localparam int DIV_CW     = $clog2(DIV_NW);
  localparam int CFG_IW     = 3;
  localparam int GROWTH_STEP = 16;
  localparam int LIM_DEN    = 5;

  localparam logic [BLK_W-1:0] BLK_MASK = (BLOCK_BITS >= BLK_W) ? {BLK_W{1'b1}} :
    BLK_W'((64'd1 << BLOCK_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_VOL_SMALL  = 3'd1,
    ST_SIZE_SMALL = 3'd2,
    ST_PROD_OVER  = 3'd3,
    ST_NO_GROUP   = 3'd4,
    ST_DERIV_SMALL = 3'd5
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_MIN_BPG = 3'd0,
    REG_MIN_G   = 3'd1,
    REG_MAX_G   = 3'd2,
    REG_MAX_BPG = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MINB_W-1:0] min_bpg;
    logic [MING_W-1:0] min_g;
    logic [REQG_W-1:0] max_g;
    logic [SIZE_W-1:0] max_bpg;
  } cfg_t;

  typedef struct packed {
    logic              go;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/cgp_cfg.sv
// Configuration register file of the geometry planner
`timescale 1ns / 1ps
module cgp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [cgp_pkg::CFG_IW-1:0]   wr_idx,
  input  logic [cgp_pkg::SIZE_W-1:0]   wr_data,
  output cgp_pkg::cfg_t                cfg
);

  logic [cgp_pkg::MINB_W-1:0] min_bpg_r;
  logic [cgp_pkg::MING_W-1:0] min_g_r;
  logic [cgp_pkg::REQG_W-1:0] max_g_r;
  logic [cgp_pkg::SIZE_W-1:0] max_bpg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bpg_r <= cgp_pkg::MINB_W'(128);
      min_g_r   <= cgp_pkg::MING_W'(1);
      max_g_r   <= cgp_pkg::REQG_W'(4096);
      max_bpg_r <= cgp_pkg::SIZE_W'(16384);
    end else if (wr_en) begin
      unique case (wr_idx)
        cgp_pkg::REG_MIN_BPG: min_bpg_r <= wr_data[cgp_pkg::MINB_W-1:0];
        cgp_pkg::REG_MIN_G:   min_g_r   <= wr_data[cgp_pkg::MING_W-1:0];
        cgp_pkg::REG_MAX_G:   max_g_r   <= wr_data[cgp_pkg::REQG_W-1:0];
        cgp_pkg::REG_MAX_BPG: max_bpg_r <= wr_data;
        default: ;
      endcase
    end
  end

  // zero reads as one
  assign cfg.min_bpg = (min_bpg_r == '0) ? cgp_pkg::MINB_W'(1) : min_bpg_r;
  assign cfg.min_g   = (min_g_r == '0)   ? cgp_pkg::MING_W'(1) : min_g_r;
  assign cfg.max_g   = (max_g_r == '0)   ? cgp_pkg::REQG_W'(1) : max_g_r;
  assign cfg.max_bpg = (max_bpg_r == '0) ? cgp_pkg::SIZE_W'(1) : max_bpg_r;

endmodule

### rtl/cgp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cgp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cgp_pkg::div_req_t req,
  output cgp_pkg::div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [cgp_pkg::DIV_CW-1:0]    cnt_r;
  logic [cgp_pkg::DIV_NW-1:0]    quo_r;
  logic [cgp_pkg::DIV_DW-1:0]    rem_r;
  logic [cgp_pkg::DIV_DW-1:0]    den_r;
  logic [cgp_pkg::DIV_DW:0]      shifted;
  logic [cgp_pkg::DIV_DW:0]      diff;
  logic                          ge;
  logic [cgp_pkg::DIV_DW-1:0]    rem_nxt;

  assign shifted = {rem_r, quo_r[cgp_pkg::DIV_NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[cgp_pkg::DIV_DW-1:0] : shifted[cgp_pkg::DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == cgp_pkg::DIV_CW'(cgp_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      quo_r <= {quo_r[cgp_pkg::DIV_NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/cgp_mul.sv
// Registered unsigned multiplier shared by the sequencer
`timescale 1ns / 1ps
module cgp_mul (
  input  logic                         clk,
  input  logic [cgp_pkg::GRP_W-1:0]    a,
  input  logic [cgp_pkg::SIZE_W-1:0]   b,
  output logic [cgp_pkg::PROD_W-1:0]   prod
);

  logic [cgp_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= cgp_pkg::PROD_W'(a) * cgp_pkg::PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

### rtl/cylinder_group_geometry_planner.sv
// Top level of the cylinder group geometry planner: sequencer and datapath
// Use: pulse start with in_block_count, in_group_request and
// in_group_size_request while busy is low; the word is taken at that edge and
// busy stays high until the answer. One result word follows per input word, shown
// for one cycle on out_status, out_group_count and out_blocks_per_group with
// out_valid high; the receiver cannot stall it and must take it then.
// Configuration: cfg_valid with cfg_index and cfg_data writes one register;
// cfg_ready is always high. Write only while busy is low.
// Sequencing: every division runs on one shared radix-2 divider (issue, bit
// steps, handoff). With both requests given the answer needs one product and no
// division; with one given, one division. With neither, the growth rule takes a
// multiply state and a compare state per step on the shared multiplier (up to
// about 12k steps), then each candidate group count in the search costs one
// division; the 20 percent bounds are shift-and-add compares.
// Reset: synchronous on rst_n low; control and configuration registers return
// to their defaults, any word at work is dropped and no result is shown.
`timescale 1ns / 1ps
module cylinder_group_geometry_planner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cgp_pkg::BLK_W-1:0]     in_block_count,
  input  logic [cgp_pkg::REQG_W-1:0]    in_group_request,
  input  logic [cgp_pkg::SIZE_W-1:0]    in_group_size_request,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [cgp_pkg::REQG_W-1:0]    out_group_count,
  output logic [cgp_pkg::SIZE_W-1:0]    out_blocks_per_group,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cgp_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [cgp_pkg::SIZE_W-1:0]    cfg_data
);

  localparam int BW = cgp_pkg::BLK_W;
  localparam int GW = cgp_pkg::GRP_W;
  localparam int SW = cgp_pkg::SIZE_W;
  localparam int WW = cgp_pkg::WASTE_W;

  typedef enum logic [13:0] {
    S_IDLE      = 14'h0001,
    S_CHECK     = 14'h0002,
    S_MUL_REQ   = 14'h0004,
    S_DIV_S     = 14'h0008,
    S_DIV_G     = 14'h0010,
    S_MUL_MAX   = 14'h0020,
    S_LIN_MUL   = 14'h0040,
    S_LIN_CMP   = 14'h0080,
    S_DIV_BASE  = 14'h0100,
    S_DIV_CLAMP = 14'h0200,
    S_SRCH      = 14'h0400,
    S_UP_DIV    = 14'h0800,
    S_DN_STEP   = 14'h1000,
    S_DN_DIV    = 14'h2000
  } state_t;

  cgp_pkg::cfg_t     cfg;
  cgp_pkg::div_req_t div_req_r, div_req_nxt;
  cgp_pkg::div_rsp_t div_rsp;

  state_t              state_r, state_nxt;
  logic [BW-1:0]       blocks_r, blocks_nxt;
  logic [cgp_pkg::REQG_W-1:0] req_g_r, req_g_nxt;
  logic [SW-1:0]       req_s_r, req_s_nxt;
  logic [GW-1:0]       cgs_r, cgs_nxt;
  logic [SW-1:0]       bpcg_r, bpcg_nxt;
  logic [GW-1:0]       tg_r, tg_nxt;
  logic [SW-1:0]       rem_r, rem_nxt;
  logic [GW-1:0]       best_g_r, best_g_nxt;
  logic [SW-1:0]       best_s_r, best_s_nxt;
  logic [WW-1:0]       best_w_r, best_w_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [cgp_pkg::REQG_W-1:0] out_g_r, out_g_nxt;
  logic [SW-1:0]       out_s_r, out_s_nxt;

  logic [GW-1:0]                mul_a;
  logic [SW-1:0]                mul_b;
  logic [cgp_pkg::PROD_W-1:0]   prod;
  logic [cgp_pkg::PROD_W-1:0]   blocks_wide;
  logic [WW-1:0]                w_up, w_dn;
  logic [GW-1:0]                cgs_dec;
  logic                         upd_dn;
  logic [BW+2:0]                ts_x5, bpcg_x4;
  logic [GW+2:0]                tg_x5, cgs_x4;

  cgp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  cgp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  cgp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign cfg_ready   = 1'b1;
  assign busy        = (state_r != S_IDLE);
  assign blocks_wide = cgp_pkg::PROD_W'(blocks_r);
  assign cgs_dec     = (cgs_r > GW'(1)) ? cgs_r - 1'b1 : cgs_r;
  assign w_up = WW'(div_rsp.rem) + WW'(tg_r) + WW'(tg_r - cgs_r);
  assign w_dn = WW'(div_rsp.rem) + WW'(tg_r) + WW'(cgs_r - tg_r);
  assign upd_dn = (w_dn < best_w_r) && (div_rsp.quot <= BW'(cfg.max_bpg));
  assign ts_x5   = (BW+3)'({div_rsp.quot, 2'b00}) + (BW+3)'(div_rsp.quot);
  assign bpcg_x4 = (BW+3)'({bpcg_r, 2'b00});
  assign tg_x5   = (GW+3)'({tg_r, 2'b00}) + (GW+3)'(tg_r);
  assign cgs_x4  = (GW+3)'({cgs_r, 2'b00});

  always_comb begin
    mul_a = GW'(cfg.max_g);
    mul_b = cfg.max_bpg;
    if (state_r == S_LIN_MUL) begin
      mul_a = cgs_r;
      mul_b = bpcg_r;
    end else if (req_g_r != '0 && req_s_r != '0) begin
      mul_a = GW'(req_g_r);
      mul_b = req_s_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    blocks_nxt     = blocks_r;
    req_g_nxt      = req_g_r;
    req_s_nxt      = req_s_r;
    cgs_nxt        = cgs_r;
    bpcg_nxt       = bpcg_r;
    tg_nxt         = tg_r;
    rem_nxt        = rem_r;
    best_g_nxt     = best_g_r;
    best_s_nxt     = best_s_r;
    best_w_nxt     = best_w_r;
    div_req_nxt    = '0;
    div_req_nxt.num = blocks_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_g_nxt      = out_g_r;
    out_s_nxt      = out_s_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          blocks_nxt = in_block_count & cgp_pkg::BLK_MASK;
          req_g_nxt  = in_group_request;
          req_s_nxt  = in_group_size_request;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (blocks_r < BW'(cfg.min_bpg)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cgp_pkg::ST_VOL_SMALL;
          out_g_nxt      = '0;
          out_s_nxt      = '0;
          state_nxt      = S_IDLE;
        end else if (req_g_r != '0 && req_s_r != '0) begin
          if (req_s_r < SW'(cfg.min_bpg)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = cgp_pkg::ST_SIZE_SMALL;
            out_g_nxt      = '0;
            out_s_nxt      = '0;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_MUL_REQ;
          end
        end else if (req_s_r != '0) begin
          div_req_nxt.go  = 1'b1;
          div_req_nxt.den = req_s_r;
          state_nxt       = S_DIV_S;
        end else if (req_g_r != '0) begin
          div_req_nxt.go  = 1'b1;
          div_req_nxt.den = SW'(req_g_r);
          state_nxt       = S_DIV_G;
        end else begin
          state_nxt = S_MUL_MAX;
        end
      end
      S_MUL_REQ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (prod > blocks_wide) begin
          out_status_nxt = cgp_pkg::ST_PROD_OVER;
          out_g_nxt      = '0;
          out_s_nxt      = '0;
        end else begin
          out_status_nxt = cgp_pkg::ST_OK;
          out_g_nxt      = req_g_r;
          out_s_nxt      = req_s_r;
        end
      end
      S_DIV_S: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (div_rsp.quot == '0) begin
            out_status_nxt = cgp_pkg::ST_NO_GROUP;
            out_g_nxt      = '0;
            out_s_nxt      = '0;
          end else begin
            out_status_nxt = cgp_pkg::ST_OK;
            out_g_nxt = (div_rsp.quot > BW'(cfg.max_g)) ? cfg.max_g :
                        div_rsp.quot[cgp_pkg::REQG_W-1:0];
            out_s_nxt = req_s_r;
          end
        end
      end
      S_DIV_G: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (div_rsp.quot < BW'(cfg.min_bpg)) begin
            out_status_nxt = cgp_pkg::ST_DERIV_SMALL;
            out_g_nxt      = '0;
            out_s_nxt      = '0;
          end else begin
            out_status_nxt = cgp_pkg::ST_OK;
            out_g_nxt      = req_g_r;
            out_s_nxt = (div_rsp.quot > BW'(cfg.max_bpg)) ? cfg.max_bpg :
                        div_rsp.quot[SW-1:0];
          end
        end
      end
      S_MUL_MAX: begin
        if (blocks_wide > prod) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cgp_pkg::ST_OK;
          out_g_nxt      = cfg.max_g;
          out_s_nxt      = cfg.max_bpg;
          state_nxt      = S_IDLE;
        end else begin
          cgs_nxt   = GW'(cfg.min_g);
          bpcg_nxt  = SW'(cfg.min_bpg);
          state_nxt = S_LIN_MUL;
        end
      end
      S_LIN_MUL: begin
        state_nxt = S_LIN_CMP;
      end
      S_LIN_CMP: begin
        if (prod < blocks_wide) begin
          cgs_nxt   = cgs_r + 1'b1;
          bpcg_nxt  = bpcg_r + SW'(cgp_pkg::GROWTH_STEP);
          state_nxt = S_LIN_MUL;
        end else begin
          cgs_nxt         = cgs_dec;
          div_req_nxt.go  = 1'b1;
          div_req_nxt.den = SW'(cgs_dec);
          state_nxt       = S_DIV_BASE;
        end
      end
      S_DIV_BASE: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > BW'(cfg.max_bpg)) begin
            bpcg_nxt        = cfg.max_bpg;
            div_req_nxt.go  = 1'b1;
            div_req_nxt.den = cfg.max_bpg;
            state_nxt       = S_DIV_CLAMP;
          end else begin
            bpcg_nxt  = div_rsp.quot[SW-1:0];
            rem_nxt   = div_rsp.rem;
            state_nxt = S_SRCH;
          end
        end
      end
      S_DIV_CLAMP: begin
        if (div_rsp.done) begin
          cgs_nxt   = div_rsp.quot[GW-1:0];
          rem_nxt   = div_rsp.rem;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (rem_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cgp_pkg::ST_OK;
          out_g_nxt      = cgs_r[cgp_pkg::REQG_W-1:0];
          out_s_nxt      = bpcg_r;
          state_nxt      = S_IDLE;
        end else begin
          best_g_nxt      = cgs_r;
          best_s_nxt      = bpcg_r;
          best_w_nxt      = WW'(rem_r) + WW'(cgs_r);
          tg_nxt          = cgs_r + 1'b1;
          div_req_nxt.go  = 1'b1;
          div_req_nxt.den = SW'(cgs_r + 1'b1);
          state_nxt       = S_UP_DIV;
        end
      end
      S_UP_DIV: begin
        if (div_rsp.done) begin
          if (w_up < best_w_r) begin
            best_g_nxt = tg_r;
            best_s_nxt = div_rsp.quot[SW-1:0];
            best_w_nxt = w_up;
          end
          if (ts_x5 > bpcg_x4 && tg_r <= GW'(cfg.max_g)) begin
            tg_nxt          = tg_r + 1'b1;
            div_req_nxt.go  = 1'b1;
            div_req_nxt.den = SW'(tg_r + 1'b1);
          end else begin
            tg_nxt    = cgs_r;
            state_nxt = S_DN_STEP;
          end
        end
      end
      S_DN_STEP: begin
        if (tg_r <= GW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cgp_pkg::ST_OK;
          out_g_nxt      = best_g_r[cgp_pkg::REQG_W-1:0];
          out_s_nxt      = best_s_r;
          state_nxt      = S_IDLE;
        end else begin
          tg_nxt          = tg_r - 1'b1;
          div_req_nxt.go  = 1'b1;
          div_req_nxt.den = SW'(tg_r - 1'b1);
          state_nxt       = S_DN_DIV;
        end
      end
      S_DN_DIV: begin
        if (div_rsp.done) begin
          if (upd_dn) begin
            best_g_nxt = tg_r;
            best_s_nxt = div_rsp.quot[SW-1:0];
            best_w_nxt = w_dn;
          end
          if (tg_x5 > cgs_x4 && div_rsp.quot <= BW'(cfg.max_bpg)) begin
            state_nxt = S_DN_STEP;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = cgp_pkg::ST_OK;
            out_g_nxt      = upd_dn ? tg_r[cgp_pkg::REQG_W-1:0] :
                             best_g_r[cgp_pkg::REQG_W-1:0];
            out_s_nxt      = upd_dn ? div_rsp.quot[SW-1:0] : best_s_r;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_req_r   <= div_req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blocks_r     <= blocks_nxt;
    req_g_r      <= req_g_nxt;
    req_s_r      <= req_s_nxt;
    cgs_r        <= cgs_nxt;
    bpcg_r       <= bpcg_nxt;
    tg_r         <= tg_nxt;
    rem_r        <= rem_nxt;
    best_g_r     <= best_g_nxt;
    best_s_r     <= best_s_nxt;
    best_w_r     <= best_w_nxt;
    out_status_r <= out_status_nxt;
    out_g_r      <= out_g_nxt;
    out_s_r      <= out_s_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_group_count      = out_g_r;
  assign out_blocks_per_group = out_s_r;

endmodule

### rtl/cgp_chk.sv
// Port-level checker for the geometry planner, bound to the top level
`timescale 1ns / 1ps
`include "cylinder_group_geometry_planner_defines.svh"
module cgp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [2:0]                    out_status,
  input logic [cgp_pkg::REQG_W-1:0]    out_group_count,
  input logic [cgp_pkg::SIZE_W-1:0]    out_blocks_per_group
);

  `CGP_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted word did not raise busy")
  `CGP_ASSERT_NEXT(a_one_pulse, out_valid, !out_valid, "result shown more than one cycle")
  `CGP_ASSERT_NOW(a_done_idle, out_valid, !busy, "busy still high with result")
  `CGP_ASSERT_NOW(a_fail_zero, out_valid && out_status != cgp_pkg::ST_OK, out_group_count == '0 && out_blocks_per_group == '0, "failed result carries geometry")
  `CGP_ASSERT_NOW(a_status_rng, out_valid, out_status <= cgp_pkg::ST_DERIV_SMALL, "status code out of range")

endmodule

bind cylinder_group_geometry_planner cgp_chk u_cgp_chk (.*);

### verif/cylinder_group_geometry_planner_tb.sv
// Self-checking testbench for the cylinder group geometry planner
`timescale 1ns / 1ps
module cylinder_group_geometry_planner_tb;

  localparam longint CYCLE_LIMIT = 500_000_000;

  typedef struct {
    cgp_pkg::status_t status;
    longint           groups;
    longint           size;
  } geometry_t;

  typedef struct {
    longint        blocks;
    longint        groups;
    longint        size;
    bit            typed;
    geometry_t     want;
  } plan_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [cgp_pkg::BLK_W-1:0]     in_block_count;
  logic [cgp_pkg::REQG_W-1:0]    in_group_request;
  logic [cgp_pkg::SIZE_W-1:0]    in_group_size_request;
  logic                          out_valid;
  logic [2:0]                    out_status;
  logic [cgp_pkg::REQG_W-1:0]    out_group_count;
  logic [cgp_pkg::SIZE_W-1:0]    out_blocks_per_group;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cgp_pkg::CFG_IW-1:0]    cfg_index;
  logic [cgp_pkg::SIZE_W-1:0]    cfg_data;

  longint    min_size_q, min_groups_q, max_groups_q, max_size_q;
  geometry_t pending_plans[$];
  bit        failed;
  longint    cycles = 0;

  cylinder_group_geometry_planner i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint floor_one(longint v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic geometry_t plan_geometry(longint blocks, longint req_g, longint req_s);
    geometry_t r;
    longint    min_s, min_g, max_g, max_s, cgs, bpcg;
    longint    best_g, best_s, best_w, tg, ts, w, lim;
    min_s = floor_one(min_size_q);
    min_g = floor_one(min_groups_q);
    max_g = floor_one(max_groups_q);
    max_s = floor_one(max_size_q);
    r.status = cgp_pkg::ST_OK;
    r.groups = 0;
    r.size   = 0;
    if (blocks < min_s) begin
      r.status = cgp_pkg::ST_VOL_SMALL;
      return r;
    end
    if (req_g > 0 && req_s > 0) begin
      if (req_s < min_s) r.status = cgp_pkg::ST_SIZE_SMALL;
      else if (req_g * req_s > blocks) r.status = cgp_pkg::ST_PROD_OVER;
      else begin
        r.groups = req_g;
        r.size   = req_s;
      end
      return r;
    end
    if (req_s > 0) begin
      cgs = blocks / req_s;
      if (cgs == 0) r.status = cgp_pkg::ST_NO_GROUP;
      else begin
        r.groups = (cgs > max_g) ? max_g : cgs;
        r.size   = req_s;
      end
      return r;
    end
    if (req_g > 0) begin
      bpcg = blocks / req_g;
      if (bpcg < min_s) r.status = cgp_pkg::ST_DERIV_SMALL;
      else begin
        r.groups = req_g;
        r.size   = (bpcg > max_s) ? max_s : bpcg;
      end
      return r;
    end
    if (blocks > max_g * max_s) begin
      r.groups = max_g & 16'hFFFF;
      r.size   = max_s & 24'hFFFFFF;
      return r;
    end
    cgs  = min_g;
    bpcg = min_s;
    while (cgs * bpcg < blocks) begin
      cgs++;
      bpcg += cgp_pkg::GROWTH_STEP;
    end
    if (cgs > 1) cgs--;
    bpcg = blocks / cgs;
    if (bpcg > max_s) begin
      bpcg = max_s;
      cgs  = blocks / max_s;
    end
    if (blocks - cgs * bpcg > 0) begin
      best_g = cgs;
      best_s = bpcg;
      best_w = blocks - cgs * bpcg + cgs;
      tg  = cgs;
      lim = (bpcg * 4) / cgp_pkg::LIM_DEN;
      do begin
        tg++;
        ts = blocks / tg;
        w  = blocks - tg * ts + tg + (tg - cgs);
        if (w < best_w) begin
          best_g = tg;
          best_s = ts;
          best_w = w;
        end
      end while (ts > lim && tg <= max_g);
      tg  = cgs;
      lim = (cgs * 4) / cgp_pkg::LIM_DEN;
      while (tg > 1) begin
        tg--;
        ts = blocks / tg;
        w  = blocks - tg * ts + tg + (cgs - tg);
        if (w < best_w && ts <= max_s) begin
          best_g = tg;
          best_s = ts;
          best_w = w;
        end
        if (!(tg > lim && ts <= max_s)) break;
      end
      cgs  = best_g;
      bpcg = best_s;
    end
    r.groups = cgs & 16'hFFFF;
    r.size   = bpcg & 24'hFFFFFF;
    return r;
  endfunction

  always @(posedge clk) begin
    geometry_t want;
    if (rst_n && out_valid) begin
      if (pending_plans.size() == 0) begin
        $display("%0t unexpected word: status %0d groups %0d size %0d", $time,
                 out_status, out_group_count, out_blocks_per_group);
        failed = 1'b1;
      end else begin
        want = pending_plans.pop_front();
        if (out_status !== want.status) begin
          $display("%0t status expected %0d actual %0d", $time, want.status, out_status);
          failed = 1'b1;
        end
        if (out_group_count !== want.groups[cgp_pkg::REQG_W-1:0]) begin
          $display("%0t group_count expected %0d actual %0d", $time, want.groups,
                   out_group_count);
          failed = 1'b1;
        end
        if (out_blocks_per_group !== want.size[cgp_pkg::SIZE_W-1:0]) begin
          $display("%0t blocks_per_group expected %0d actual %0d", $time, want.size,
                   out_blocks_per_group);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_plan(longint blocks, longint req_g, longint req_s, bit typed,
                           geometry_t want);
    @(negedge clk);
    start                 <= 1'b1;
    in_block_count        <= blocks[cgp_pkg::BLK_W-1:0];
    in_group_request      <= req_g[cgp_pkg::REQG_W-1:0];
    in_group_size_request <= req_s[cgp_pkg::SIZE_W-1:0];
    do @(posedge clk); while (busy);
    pending_plans.push_back(typed ? want :
      plan_geometry(blocks & cgp_pkg::BLK_MASK, req_g & 16'hFFFF, req_s & 24'hFFFFFF));
    @(negedge clk);
    start <= 1'b0;
    sender_gap();
  endtask

  task automatic drain();
    while (pending_plans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cgp_pkg::reg_idx_t idx, longint value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[cgp_pkg::SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cgp_pkg::REG_MIN_BPG: min_size_q   = value & 16'hFFFF;
      cgp_pkg::REG_MIN_G:   min_groups_q = value & 12'hFFF;
      cgp_pkg::REG_MAX_G:   max_groups_q = value & 16'hFFFF;
      cgp_pkg::REG_MAX_BPG: max_size_q   = value & 24'hFFFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(longint min_s, longint min_g, longint max_g, longint max_s);
    drain();
    write_reg(cgp_pkg::REG_MIN_BPG, min_s);
    write_reg(cgp_pkg::REG_MIN_G, min_g);
    write_reg(cgp_pkg::REG_MAX_G, max_g);
    write_reg(cgp_pkg::REG_MAX_BPG, max_s);
  endtask

  task automatic random_plans(int count);
    longint blocks, req_g, req_s;
    int     pick;
    geometry_t none;
    none = '{cgp_pkg::ST_OK, 0, 0};
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) blocks = $urandom_range(0, 1 << 20);
      else if (pick < 9) blocks = $urandom_range(0, 1 << 26);
      else blocks = $urandom & 32'h7FFF_FFFF;
      req_g = ($urandom_range(0, 1)) ? $urandom_range(1, 300) : ($urandom & 16'hFFFF);
      req_s = ($urandom_range(0, 1)) ? $urandom_range(1, 5000) : ($urandom & 24'hFFFFFF);
      case ($urandom_range(0, 3))
        0: begin req_g = 0; req_s = 0; end
        1: req_g = 0;
        2: req_s = 0;
        default: ;
      endcase
      send_plan(blocks, req_g, req_s, 1'b0, none);
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  plan_row_t plan_table[] = '{
    '{0,          0,     0,        1, '{cgp_pkg::ST_VOL_SMALL, 0, 0}},
    '{127,        5,     200,      1, '{cgp_pkg::ST_VOL_SMALL, 0, 0}},
    '{1000,       4,     100,      1, '{cgp_pkg::ST_SIZE_SMALL, 0, 0}},
    '{1000,       8,     128,      1, '{cgp_pkg::ST_PROD_OVER, 0, 0}},
    '{1000,       7,     128,      1, '{cgp_pkg::ST_OK, 7, 128}},
    '{1000,       0,     2000,     1, '{cgp_pkg::ST_NO_GROUP, 0, 0}},
    '{1000,       10,    0,        1, '{cgp_pkg::ST_DERIV_SMALL, 0, 0}},
    '{2147483647, 65535, 16777215, 1, '{cgp_pkg::ST_PROD_OVER, 0, 0}},
    '{2147483647, 0,     0,        1, '{cgp_pkg::ST_OK, 4096, 16384}},
    '{2147483647, 1,     0,        1, '{cgp_pkg::ST_OK, 1, 16384}},
    '{2147483647, 0,     1,        1, '{cgp_pkg::ST_OK, 4096, 1}},
    '{128,        0,     0,        0, '{cgp_pkg::ST_OK, 0, 0}},
    '{129,        0,     0,        0, '{cgp_pkg::ST_OK, 0, 0}},
    '{1000,       0,     0,        0, '{cgp_pkg::ST_OK, 0, 0}},
    '{100000,     0,     0,        0, '{cgp_pkg::ST_OK, 0, 0}},
    '{67108864,   0,     0,        0, '{cgp_pkg::ST_OK, 0, 0}},
    '{1431655765, 43690, 11184810, 0, '{cgp_pkg::ST_OK, 0, 0}},
    '{715827882,  21845, 5592405,  0, '{cgp_pkg::ST_OK, 0, 0}},
    '{5000,       3,     0,        0, '{cgp_pkg::ST_OK, 0, 0}},
    '{5000,       0,     300,      0, '{cgp_pkg::ST_OK, 0, 0}}
  };

  initial begin
    failed                = 1'b0;
    rst_n                 = 1'b0;
    start                 = 1'b0;
    in_block_count        = '0;
    in_group_request      = '0;
    in_group_size_request = '0;
    cfg_valid             = 1'b0;
    cfg_index             = cgp_pkg::REG_MIN_BPG;
    cfg_data              = '0;
    min_size_q            = 128;
    min_groups_q          = 1;
    max_groups_q          = 4096;
    max_size_q            = 16384;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_table[i])
      send_plan(plan_table[i].blocks, plan_table[i].groups, plan_table[i].size,
                plan_table[i].typed, plan_table[i].want);

    random_plans(20);
    configure(1, 4095, 65535, 16777215);
    random_plans(15);
    configure(0, 0, 0, 0);
    random_plans(15);
    configure(65535, 1, 1, 16);
    random_plans(15);
    configure(64, 200, 1000, 100000);
    random_plans(15);
    configure(300, 3, 65535, 300);
    random_plans(15);
    drain();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cgp_pkg.sv
rtl/cgp_cfg.sv
rtl/cgp_div.sv
rtl/cgp_mul.sv
rtl/cylinder_group_geometry_planner.sv
rtl/cgp_chk.sv
verif/cylinder_group_geometry_planner_tb.sv
